>>> rtl/set_assoc_lru_cache_tags_unit_assert.svh
`ifndef SET_ASSOC_LRU_CACHE_TAGS_UNIT_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_UNIT_ASSERT_SVH

// Both macros expect signals named clk and rst in the scope where they are used.
`define SALRU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define SALRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/salru_pkg.sv
package salru_pkg;

  localparam int ADDRESS_W   = 32;
  localparam int READ_LAT_W  = 16;
  localparam int WRITE_LAT_W = 16;
  localparam int MEM_LAT_W   = 20;
  localparam int LAT_W       = 22;
  localparam int WAY_OUT_W   = 2;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_READ_LATENCY  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_LATENCY = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_MEM_LATENCY   = CFG_INDEX_W'(2);

  localparam logic [READ_LAT_W-1:0]  READ_LAT_RESET  = 16'd1000;
  localparam logic [WRITE_LAT_W-1:0] WRITE_LAT_RESET = 16'd1000;
  localparam logic [MEM_LAT_W-1:0]   MEM_LAT_RESET   = 20'd66000;

  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic [READ_LAT_W-1:0]  read_latency;
    logic [WRITE_LAT_W-1:0] write_latency;
    logic [MEM_LAT_W-1:0]   mem_latency;
  } cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_RESOLVE
  } back_state_t;

  function automatic int flog2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n++;
    end
    return n;
  endfunction

  function automatic int tag_width(input int sets, input int line_bytes, input int addr_bits);
    int ab;
    int t;
    ab = (addr_bits < ADDRESS_W) ? addr_bits : ADDRESS_W;
    t = ab - flog2(line_bytes) - flog2(sets);
    return (t > 0) ? t : 1;
  endfunction

endpackage

>>> rtl/salru_req_if.sv
interface salru_req_if;
  import salru_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [ADDRESS_W-1:0] address;

  modport source(output valid, output req_type, output address, input ready);
  modport sink(input valid, input req_type, input address, output ready);
endinterface

>>> rtl/salru_rsp_if.sv
interface salru_rsp_if;
  import salru_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 dirty_evict;
  logic [WAY_OUT_W-1:0] way_used;
  logic [LAT_W-1:0]     latency;

  modport source(output valid, output hit, output dirty_evict, output way_used,
                 output latency, input ready);
  modport sink(input valid, input hit, input dirty_evict, input way_used,
               input latency, output ready);
endinterface

>>> rtl/salru_front.sv
module salru_front #(
  parameter int SETS       = 64,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 32,
  localparam int SB     = salru_pkg::flog2(SETS),
  localparam int SET_W  = (SB > 0) ? SB : 1,
  localparam int TAG_W  = salru_pkg::tag_width(SETS, LINE_BYTES, ADDR_BITS),
  localparam int ITEM_W = 1 + SET_W + TAG_W
) (
  input  logic                  clk,
  input  logic                  rst,
  salru_req_if.sink             req,
  input  logic                  accept_en,
  input  salru_pkg::q_status_t  q_status,
  output logic                  push,
  output logic [ITEM_W-1:0]     push_item
);
  import salru_pkg::*;

  localparam int OB = flog2(LINE_BYTES);
  localparam logic [ADDRESS_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDRESS_W) ? '1 :
    ADDRESS_W'((64'd1 << ADDR_BITS) - 64'd1);

  logic                 slot_valid;
  logic                 slot_valid_next;
  logic [ITEM_W-1:0]    slot;
  logic [ADDRESS_W-1:0] addr_m;
  logic [ADDRESS_W-1:0] set_field;
  logic [ADDRESS_W-1:0] tag_field;
  logic [SET_W-1:0]     set_idx;
  logic [TAG_W-1:0]     tag;
  logic                 accept;

  always_comb begin
    addr_m    = req.address & ADDR_MASK;
    set_field = addr_m >> OB;
    tag_field = addr_m >> (OB + SB);
    set_idx   = (SB > 0) ? set_field[SET_W-1:0] : '0;
    tag       = tag_field[TAG_W-1:0];
  end

  assign push      = slot_valid && !q_status.full;
  assign req.ready = accept_en && (!slot_valid || push);
  assign accept    = req.valid && req.ready;
  assign push_item = slot;

  always_comb begin
    if (accept) begin
      slot_valid_next = 1'b1;
    end else if (push) begin
      slot_valid_next = 1'b0;
    end else begin
      slot_valid_next = slot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else begin
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot <= {req.req_type == REQ_WRITE, set_idx, tag};
    end
  end

endmodule

>>> rtl/salru_queue.sv
module salru_queue #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     pop_data,
  output salru_pkg::q_status_t status
);
  import salru_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      count <= CNT_W'(count + CNT_W'(push) - CNT_W'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign pop_data     = entries[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(DEPTH));

endmodule

>>> rtl/salru_back.sv
module salru_back #(
  parameter int WAYS       = 4,
  parameter int SETS       = 64,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 32,
  localparam int SB     = salru_pkg::flog2(SETS),
  localparam int SET_W  = (SB > 0) ? SB : 1,
  localparam int TAG_W  = salru_pkg::tag_width(SETS, LINE_BYTES, ADDR_BITS),
  localparam int ITEM_W = 1 + SET_W + TAG_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  salru_pkg::cfg_t      cfg,
  input  salru_pkg::q_status_t q_status,
  input  logic [ITEM_W-1:0]    pop_item,
  output logic                 pop,
  output logic                 init_done,
  salru_rsp_if.source          rsp
);
  import salru_pkg::*;

  localparam int SET_ROWS = 1 << SB;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  back_state_t state;
  back_state_t state_next;

  logic             clearing;
  logic             resolve_fire;
  logic [SET_W-1:0] clear_idx;
  logic [SET_W-1:0] pop_set;

  logic             cur_write;
  logic [SET_W-1:0] cur_set;
  logic [TAG_W-1:0] cur_tag;

  logic [WAYS-1:0][TAG_W-1:0] tag_mem   [SET_ROWS];
  logic [WAYS-1:0]            valid_mem [SET_ROWS];
  logic [WAYS-1:0]            dirty_mem [SET_ROWS];
  logic [WAYS-1:0][WAY_W-1:0] lru_mem   [SET_ROWS];

  logic [WAYS-1:0][TAG_W-1:0] tag_rd;
  logic [WAYS-1:0]            valid_rd;
  logic [WAYS-1:0]            dirty_rd;
  logic [WAYS-1:0][WAY_W-1:0] lru_rd;

  logic                       meta_we;
  logic [SET_W-1:0]           meta_addr;
  logic [WAYS-1:0]            valid_wr;
  logic [WAYS-1:0]            dirty_wr;
  logic [WAYS-1:0][WAY_W-1:0] lru_wr;
  logic [WAYS-1:0][WAY_W-1:0] lru_ident;

  logic                       hit;
  logic                       found;
  logic                       wb;
  logic                       seen;
  logic [WAY_W-1:0]           hit_way;
  logic [WAY_W-1:0]           inv_way;
  logic [WAY_W-1:0]           victim;
  logic [WAY_W-1:0]           way;
  logic [WAYS-1:0]            valid_new;
  logic [WAYS-1:0]            dirty_new;
  logic [WAYS-1:0][TAG_W-1:0] tag_new;
  logic [WAYS-1:0][WAY_W-1:0] lru_new;
  logic [LAT_W-1:0]           rd_ext;
  logic [LAT_W-1:0]           wr_ext;
  logic [LAT_W-1:0]           mem_ext;
  logic [LAT_W-1:0]           lat;

  logic                 out_valid;
  logic                 out_hit;
  logic                 out_dirty_evict;
  logic [WAY_OUT_W-1:0] out_way;
  logic [LAT_W-1:0]     out_latency;

  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR: begin
        if (clear_idx == SET_W'(SET_ROWS - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_status.empty) begin
          state_next = B_RESOLVE;
        end
      end
      B_RESOLVE: begin
        if (!out_valid || rsp.ready) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_CLEAR;
      end
    endcase
  end

  always_comb begin
    clearing     = 1'b0;
    pop          = 1'b0;
    resolve_fire = 1'b0;
    init_done    = 1'b1;
    case (state)
      B_CLEAR: begin
        clearing  = 1'b1;
        init_done = 1'b0;
      end
      B_IDLE: begin
        pop = !q_status.empty;
      end
      B_RESOLVE: begin
        resolve_fire = !out_valid || rsp.ready;
      end
      default: begin
        init_done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clear_idx <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clear_idx <= SET_W'(clear_idx + 1'b1);
      end
    end
  end

  assign pop_set = pop_item[TAG_W +: SET_W];

  always_ff @(posedge clk) begin
    if (pop) begin
      {cur_write, cur_set, cur_tag} <= pop_item;
    end
  end

  always_comb begin
    for (int k = 0; k < WAYS; k++) begin
      lru_ident[k] = WAY_W'(k);
    end
  end

  assign meta_we   = clearing || resolve_fire;
  assign meta_addr = clearing ? clear_idx : cur_set;
  assign valid_wr  = clearing ? '0 : valid_new;
  assign dirty_wr  = clearing ? '0 : dirty_new;
  assign lru_wr    = clearing ? lru_ident : lru_new;

  always_ff @(posedge clk) begin
    if (resolve_fire) begin
      tag_mem[cur_set] <= tag_new;
    end
    if (pop) begin
      tag_rd <= tag_mem[pop_set];
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      valid_mem[meta_addr] <= valid_wr;
      dirty_mem[meta_addr] <= dirty_wr;
      lru_mem[meta_addr]   <= lru_wr;
    end
    if (pop) begin
      valid_rd <= valid_mem[pop_set];
      dirty_rd <= dirty_mem[pop_set];
      lru_rd   <= lru_mem[pop_set];
    end
  end

  always_comb begin
    hit     = 1'b0;
    found   = 1'b0;
    hit_way = '0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid_rd[w] && (tag_rd[w] == cur_tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!valid_rd[w]) begin
        found   = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
    victim = lru_rd[0];
    way    = hit ? hit_way : (found ? inv_way : victim);
    wb     = !hit && !found && dirty_rd[victim];

    valid_new      = valid_rd;
    valid_new[way] = 1'b1;
    dirty_new      = dirty_rd;
    dirty_new[way] = hit ? (dirty_rd[way] || cur_write) : cur_write;
    tag_new        = tag_rd;
    tag_new[way]   = cur_tag;

    // The used way leaves its place in the order and moves to the most recent end.
    seen = 1'b0;
    for (int k = 0; k < WAYS; k++) begin
      seen = seen || (lru_rd[k] == way);
      if (k < WAYS - 1) begin
        lru_new[k] = seen ? lru_rd[(k + 1) % WAYS] : lru_rd[k];
      end else begin
        lru_new[k] = way;
      end
    end

    rd_ext  = LAT_W'(cfg.read_latency);
    wr_ext  = LAT_W'(cfg.write_latency);
    mem_ext = LAT_W'(cfg.mem_latency);
    if (hit) begin
      lat = cur_write ? wr_ext : rd_ext;
    end else begin
      lat = LAT_W'(mem_ext + (wb ? mem_ext : '0) + (cur_write ? wr_ext : '0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resolve_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resolve_fire) begin
      out_hit         <= hit;
      out_dirty_evict <= wb;
      out_way         <= WAY_OUT_W'(way);
      out_latency     <= lat;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.hit         = out_hit;
  assign rsp.dirty_evict = out_dirty_evict;
  assign rsp.way_used    = out_way;
  assign rsp.latency     = out_latency;

endmodule

>>> rtl/set_assoc_lru_cache_tags_unit.sv
// Tag, valid, dirty and LRU bookkeeping for a set-associative write-back,
// write-allocate cache. Requests (read or write, byte address) arrive on the
// req channel; one result per request (hit, dirty eviction, way used and the
// access time in picoseconds) leaves on the rsp channel in request order.
// The three latency registers are written through cfg_write, cfg_index and
// cfg_data; writes to other indexes are ignored. The user must write them
// only while the block is idle; the block itself does not enforce it. An
// accepted request is decoded into a holding register, passes a two-entry
// queue and is resolved by the lookup engine, which reads the set in its idle
// state and writes back the updated tags, valid, dirty and LRU order in its
// resolve state; it takes no new request before it is through with the last
// one. After reset a clearing pass writes every set's valid, dirty and LRU
// state, one set per cycle; req.ready stays low until it ends, while
// configuration writes are taken at once.
// When rsp is stalled the result is held in the output register, the lookup
// engine waits with the next request, and the queue and holding register
// absorb up to three more requests before req.ready falls.
module set_assoc_lru_cache_tags_unit #(
  parameter int WAYS       = 4,
  parameter int SETS       = 64,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  salru_req_if.sink                        req,
  salru_rsp_if.source                      rsp,
  input  logic                             cfg_write,
  input  logic [salru_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import salru_pkg::*;

  localparam int SB     = flog2(SETS);
  localparam int SET_W  = (SB > 0) ? SB : 1;
  localparam int TAG_W  = tag_width(SETS, LINE_BYTES, ADDR_BITS);
  localparam int ITEM_W = 1 + SET_W + TAG_W;

  cfg_t              cfg;
  q_status_t         q_status;
  logic              push;
  logic              pop;
  logic              init_done;
  logic [ITEM_W-1:0] push_item;
  logic [ITEM_W-1:0] pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.read_latency  <= READ_LAT_RESET;
      cfg.write_latency <= WRITE_LAT_RESET;
      cfg.mem_latency   <= MEM_LAT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_READ_LATENCY:  cfg.read_latency  <= cfg_data[READ_LAT_W-1:0];
        CFG_WRITE_LATENCY: cfg.write_latency <= cfg_data[WRITE_LAT_W-1:0];
        CFG_MEM_LATENCY:   cfg.mem_latency   <= cfg_data[MEM_LAT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  salru_front #(
    .SETS       (SETS),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .accept_en (init_done),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  salru_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_item),
    .pop       (pop),
    .pop_data  (pop_item),
    .status    (q_status)
  );

  salru_back #(
    .WAYS       (WAYS),
    .SETS       (SETS),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_status  (q_status),
    .pop_item  (pop_item),
    .pop       (pop),
    .init_done (init_done),
    .rsp       (rsp)
  );

endmodule

>>> rtl/salru_checker.sv
`include "set_assoc_lru_cache_tags_unit_assert.svh"

module salru_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic                            rsp_hit,
  input logic                            rsp_dirty_evict,
  input logic [salru_pkg::WAY_OUT_W-1:0] rsp_way_used,
  input logic [salru_pkg::LAT_W-1:0]     rsp_latency
);
  import salru_pkg::*;

  logic [3:0] outstanding;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = req_valid && req_ready;
  assign out_acc = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= 4'(outstanding + {3'b0, in_acc} - {3'b0, out_acc});
    end
  end

  `SALRU_ASSERT_NOW(a_clear_blocks_req, $fell(rst), !req_ready && !rsp_valid, "request taken during clearing pass")
  `SALRU_ASSERT_NOW(a_rsp_has_req, rsp_valid, outstanding != 4'd0, "result without a pending request")
  `SALRU_ASSERT_NOW(a_evict_is_miss, rsp_valid && rsp_dirty_evict, !rsp_hit, "dirty eviction reported on a hit")
  `SALRU_ASSERT_NOW(a_hit_latency, rsp_valid && rsp_hit, rsp_latency[LAT_W-1:WRITE_LAT_W] == '0, "hit latency exceeds register range")
  `SALRU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_dirty_evict) && $stable(rsp_way_used) && $stable(rsp_latency), "stalled result changed")

endmodule

bind set_assoc_lru_cache_tags_unit salru_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_hit         (rsp.hit),
  .rsp_dirty_evict (rsp.dirty_evict),
  .rsp_way_used    (rsp.way_used),
  .rsp_latency     (rsp.latency)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import salru_pkg::*;

  localparam int NUM_WAYS = 4;
  localparam int NUM_SETS = 64;
  localparam int OFFSET_W = 6;
  localparam int SET_W = 6;
  localparam int TAG_W = ADDRESS_W - OFFSET_W - SET_W;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int DIRECTED_ROWS = 20;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = CFG_INDEX_W'(3);
  localparam logic REQ_READ = ~REQ_WRITE;

  typedef struct packed {
    logic                 hit;
    logic                 dirty_evict;
    logic [WAY_OUT_W-1:0] way_used;
    logic [LAT_W-1:0]     latency;
  } access_result_t;

  typedef struct {
    logic                 req_type;
    logic [ADDRESS_W-1:0] address;
    bit                   typed;
    access_result_t       result;
  } access_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  salru_req_if req_ch ();
  salru_rsp_if rsp_ch ();

  set_assoc_lru_cache_tags_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [TAG_W-1:0] line_tag [NUM_SETS][NUM_WAYS];
  bit line_valid [NUM_SETS][NUM_WAYS];
  bit line_dirty [NUM_SETS][NUM_WAYS];
  int lru_list [NUM_SETS][NUM_WAYS];
  logic [READ_LAT_W-1:0] lat_read;
  logic [WRITE_LAT_W-1:0] lat_write;
  logic [MEM_LAT_W-1:0] lat_mem;

  access_result_t pending_results [$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit send_idle;
  bit rsp_stall;

  access_row_t access_rows [DIRECTED_ROWS] = '{
    '{REQ_READ,  32'h0000_0000, 1'b1, '{1'b0, 1'b0, 2'd0, 22'd66000}},
    '{REQ_WRITE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 2'd0, 22'd67000}},
    '{REQ_READ,  32'h0000_003F, 1'b1, '{1'b1, 1'b0, 2'd0, 22'd1000}},
    '{REQ_WRITE, 32'hFFFF_FFC0, 1'b1, '{1'b1, 1'b0, 2'd0, 22'd1000}},
    '{REQ_WRITE, 32'h0000_1004, 1'b0, '0},
    '{REQ_WRITE, 32'h0000_2008, 1'b0, '0},
    '{REQ_READ,  32'h0000_3010, 1'b0, '0},
    '{REQ_READ,  32'h0000_4000, 1'b0, '0},
    '{REQ_READ,  32'h0000_5000, 1'b0, '0},
    '{REQ_WRITE, 32'h0000_6000, 1'b0, '0},
    '{REQ_WRITE, 32'h0000_4020, 1'b0, '0},
    '{REQ_READ,  32'h0000_1000, 1'b0, '0},
    '{REQ_READ,  32'h0000_2000, 1'b0, '0},
    '{REQ_WRITE, 32'h0000_3000, 1'b0, '0},
    '{REQ_READ,  32'h0000_0FFF, 1'b0, '0},
    '{REQ_WRITE, 32'h0001_0FC0, 1'b0, '0},
    '{REQ_WRITE, 32'h8000_0FC0, 1'b0, '0},
    '{REQ_READ,  32'h7FFF_FFFF, 1'b0, '0},
    '{REQ_READ,  32'h8000_0FC4, 1'b0, '0},
    '{REQ_READ,  32'h0000_0800, 1'b0, '0}
  };

  task automatic clear_cache_model();
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        line_tag[s][w] = '0;
        line_valid[s][w] = 1'b0;
        line_dirty[s][w] = 1'b0;
        lru_list[s][w] = w;
      end
    end
    lat_read = READ_LAT_RESET;
    lat_write = WRITE_LAT_RESET;
    lat_mem = MEM_LAT_RESET;
  endtask

  function automatic access_result_t predict_access(input logic kind,
                                                    input logic [ADDRESS_W-1:0] addr);
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag;
    int way;
    int pos;
    bit hit;
    bit free_found;
    bit write_back;
    int unsigned total;
    access_result_t r;
    set_idx = addr[OFFSET_W +: SET_W];
    tag = addr[ADDRESS_W-1 -: TAG_W];
    hit = 1'b0;
    free_found = 1'b0;
    write_back = 1'b0;
    way = 0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!hit && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
        hit = 1'b1;
        way = w;
      end
    end
    if (hit) begin
      if (kind == REQ_WRITE) line_dirty[set_idx][way] = 1'b1;
      total = (kind == REQ_WRITE) ? int'(lat_write) : int'(lat_read);
    end else begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (!free_found && !line_valid[set_idx][w]) begin
          free_found = 1'b1;
          way = w;
        end
      end
      if (!free_found) begin
        way = lru_list[set_idx][0];
        write_back = line_dirty[set_idx][way];
      end
      line_tag[set_idx][way] = tag;
      line_valid[set_idx][way] = 1'b1;
      line_dirty[set_idx][way] = (kind == REQ_WRITE);
      total = int'(lat_mem);
      if (write_back) total += int'(lat_mem);
      if (kind == REQ_WRITE) total += int'(lat_write);
    end
    pos = 0;
    for (int k = 0; k < NUM_WAYS; k++) begin
      if (lru_list[set_idx][k] == way) pos = k;
    end
    for (int k = pos; k < NUM_WAYS - 1; k++) lru_list[set_idx][k] = lru_list[set_idx][k + 1];
    lru_list[set_idx][NUM_WAYS - 1] = way;
    r.hit = hit;
    r.dirty_evict = write_back;
    r.way_used = WAY_OUT_W'(way);
    r.latency = LAT_W'(total);
    return r;
  endfunction

  function automatic logic [ADDRESS_W-1:0] pick_address();
    logic [TAG_W-1:0] tag;
    logic [SET_W-1:0] set_idx;
    logic [OFFSET_W-1:0] offset;
    int mode;
    mode = $urandom_range(0, 9);
    offset = OFFSET_W'($urandom);
    set_idx = (mode < 6) ? SET_W'($urandom_range(0, 3)) : SET_W'($urandom);
    if (mode == 0) tag = TAG_W'($urandom);
    else if (mode < 4) tag = TAG_W'($urandom_range(0, 5));
    else tag = ~TAG_W'($urandom_range(0, 5));
    return {tag, set_idx, offset};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_result();
    access_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: hit %0b way %0d latency %0d",
                                rsp_ch.hit, rsp_ch.way_used, rsp_ch.latency));
    end else begin
      want = pending_results.pop_front();
      if (rsp_ch.hit !== want.hit)
        report_mismatch($sformatf("hit %0b, expected %0b", rsp_ch.hit, want.hit));
      if (rsp_ch.dirty_evict !== want.dirty_evict)
        report_mismatch($sformatf("dirty_evict %0b, expected %0b",
                                  rsp_ch.dirty_evict, want.dirty_evict));
      if (rsp_ch.way_used !== want.way_used)
        report_mismatch($sformatf("way_used %0d, expected %0d", rsp_ch.way_used, want.way_used));
      if (rsp_ch.latency !== want.latency)
        report_mismatch($sformatf("latency %0d, expected %0d", rsp_ch.latency, want.latency));
    end
  endtask

  task automatic send_access(input logic kind, input logic [ADDRESS_W-1:0] addr,
                             input bit typed, input access_result_t typed_result);
    int gap;
    access_result_t predicted;
    gap = send_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.address <= addr;
    do @(posedge clk); while (!req_ch.ready);
    predicted = predict_access(kind, addr);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_latencies(input logic [CFG_DATA_W-1:0] rd, input logic [CFG_DATA_W-1:0] wr,
                                input logic [CFG_DATA_W-1:0] mem);
    logic [CFG_INDEX_W-1:0] idx_list [4];
    logic [CFG_DATA_W-1:0] val_list [4];
    idx_list = '{CFG_READ_LATENCY, CFG_WRITE_LATENCY, CFG_MEM_LATENCY, CFG_UNUSED_INDEX};
    val_list = '{rd, wr, mem, CFG_DATA_W'($urandom)};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data <= val_list[i];
      @(posedge clk);
      case (idx_list[i])
        CFG_READ_LATENCY: lat_read = val_list[i][READ_LAT_W-1:0];
        CFG_WRITE_LATENCY: lat_write = val_list[i][WRITE_LAT_W-1:0];
        CFG_MEM_LATENCY: lat_mem = val_list[i][MEM_LAT_W-1:0];
        default: ;
      endcase
    end
    cfg_write <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        check_result();
        stall_left = rsp_stall ? $urandom_range(0, 19) : 0;
        rsp_ch.ready <= (stall_left == 0);
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_write) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_READ;
    req_ch.address = '0;
    rsp_ch.ready = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_READ_LATENCY;
    cfg_data = '0;
    send_idle = 1'b1;
    rsp_stall = 1'b1;
    clear_cache_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (access_rows[i]) begin
      send_access(access_rows[i].req_type, access_rows[i].address, access_rows[i].typed,
                  access_rows[i].result);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: load_latencies('0, '0, '0);
        1: load_latencies('1, '1, '1);
        3: load_latencies(CFG_DATA_W'(READ_LAT_RESET), CFG_DATA_W'(WRITE_LAT_RESET),
                          MEM_LAT_RESET);
        default: load_latencies(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                CFG_DATA_W'($urandom));
      endcase
      send_idle = (phase % 3 != 0);
      rsp_stall = (phase % 2 != 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) == 0) drain();
        send_access(1'($urandom_range(0, 1)), pick_address(), 1'b0, '0);
      end
    end

    drain();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/salru_pkg.sv
rtl/salru_req_if.sv
rtl/salru_rsp_if.sv
rtl/salru_front.sv
rtl/salru_queue.sv
rtl/salru_back.sv
rtl/set_assoc_lru_cache_tags_unit.sv
rtl/salru_checker.sv
test/tb_top.sv
